@@ rtl/ctfc_pkg.sv @@
package ctfc_pkg;

    // Field widths of the hit and feature channels.
    localparam int TIME_W   = 31;
    localparam int CHARGE_W = 24;
    localparam int DC_W     = 10;
    localparam int QSUM_W   = 32;
    localparam int BAL_W    = 20;
    localparam int RATIO_W  = 24;
    localparam int TOTAL_W  = 9;
    localparam int STATUS_W = 2;

    // Hit counter limit of one cluster; hit_total is sized for it.
    localparam int MAX_HITS = 256;

    // Shared divider and square-root unit sizes.
    localparam int DIV_NUM_W  = 96;
    localparam int DIV_DEN_W  = 64;
    localparam int ROOT_W     = 40;
    localparam int ROOT_STEPS = 20;

    localparam logic [DC_W-1:0] DC_RESET = 10'd123;

    // Operations run on the shared divider, in the order the controller issues them.
    typedef enum logic [2:0] {
        OP_MEAN,
        OP_RECIP,
        OP_XDIV,
        OP_SPAN_PEAK,
        OP_SPAN_MEAN,
        OP_PEAK_MEAN
    } div_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    acc;
        logic    qq_load;
        logic    span_load;
        logic    div_start;
        div_op_t div_op;
        logic    root_init;
        logic    root_step;
        logic    out_load;
    } ctfc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } ctfc_stat_t;

endpackage

@@ rtl/ctfc_hit_if.sv @@
interface ctfc_hit_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ctfc_pkg::TIME_W-1:0]    hit_time;
    logic signed [ctfc_pkg::CHARGE_W-1:0]  hit_charge;
    logic                                  hit_selected;
    logic                                  last_hit;

    modport source (output valid, hit_time, hit_charge, hit_selected, last_hit, input ready);
    modport sink (input valid, hit_time, hit_charge, hit_selected, last_hit, output ready);
endinterface

@@ rtl/ctfc_feat_if.sv @@
interface ctfc_feat_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ctfc_pkg::TIME_W-1:0]   mean_time;
    logic signed [ctfc_pkg::QSUM_W-1:0]   total_charge;
    logic [ctfc_pkg::BAL_W-1:0]           charge_spread;
    logic [ctfc_pkg::TIME_W-1:0]          time_span;
    logic [ctfc_pkg::TIME_W-1:0]          span_about_mean;
    logic [ctfc_pkg::TIME_W-1:0]          span_about_peak;
    logic [ctfc_pkg::RATIO_W-1:0]         ratio_span_peak;
    logic [ctfc_pkg::RATIO_W-1:0]         ratio_span_mean;
    logic [ctfc_pkg::RATIO_W-1:0]         ratio_peak_mean;
    logic [ctfc_pkg::TOTAL_W-1:0]         hit_total;
    logic [ctfc_pkg::STATUS_W-1:0]        status;

    modport source (output valid, mean_time, total_charge, charge_spread, time_span,
                    span_about_mean, span_about_peak, ratio_span_peak, ratio_span_mean,
                    ratio_peak_mean, hit_total, status, input ready);
    modport sink (input valid, mean_time, total_charge, charge_spread, time_span,
                  span_about_mean, span_about_peak, ratio_span_peak, ratio_span_mean,
                  ratio_peak_mean, hit_total, status, output ready);
endinterface

@@ rtl/cluster_time_charge_features_core.sv @@
// Channel    Direction  Transfer when         Contents
// hit_in     in         valid && ready        one hit: time, charge, selected, last mark
// feat_out   out        valid && ready        one feature set per cluster
// cfg        in         cfg_wr_en             detector_count, no read-back
//
// A hit without the last mark leaves the hit input ready for the next hit.
// A last hit starts six 96-step runs of the shared restoring divider and a 20-step
// square root; the result register is loaded once all of them have finished.
// The hit input is held off from the last hit until the result is loaded, and longer
// while the previous result has not been taken.
// Reset clears all cluster sums and sets detector_count to 123.
module cluster_time_charge_features_core (
    input  logic                          clk,
    input  logic                          rst_n,
    ctfc_hit_if.sink                      hit_in,
    ctfc_feat_if.source                   feat_out,
    input  logic                          cfg_wr_en,
    input  logic [ctfc_pkg::DC_W-1:0]     cfg_wr_data
);
    ctfc_pkg::ctfc_cmd_t  cmd;
    ctfc_pkg::ctfc_stat_t stat;

    ctfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hit_in.valid),
        .in_last   (hit_in.last_hit),
        .in_ready  (hit_in.ready),
        .out_ready (feat_out.ready),
        .out_valid (feat_out.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    ctfc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .hit_time        (hit_in.hit_time),
        .hit_charge      (hit_in.hit_charge),
        .hit_selected    (hit_in.hit_selected),
        .mean_time       (feat_out.mean_time),
        .total_charge    (feat_out.total_charge),
        .charge_spread   (feat_out.charge_spread),
        .time_span       (feat_out.time_span),
        .span_about_mean (feat_out.span_about_mean),
        .span_about_peak (feat_out.span_about_peak),
        .ratio_span_peak (feat_out.ratio_span_peak),
        .ratio_span_mean (feat_out.ratio_span_mean),
        .ratio_peak_mean (feat_out.ratio_peak_mean),
        .hit_total       (feat_out.hit_total),
        .status          (feat_out.status)
    );
endmodule

@@ rtl/ctfc_div.sv @@
module ctfc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [ctfc_pkg::DIV_NUM_W-1:0]     num,
    input  logic [ctfc_pkg::DIV_DEN_W-1:0]     den,
    output logic [ctfc_pkg::DIV_NUM_W-1:0]     quot,
    output logic                               done
);
    localparam int NW  = ctfc_pkg::DIV_NUM_W;
    localparam int DW  = ctfc_pkg::DIV_DEN_W;
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  q_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;
    logic [CNW-1:0] cnt_reg;
    logic           done_reg;
    logic [DW:0]    shifted;
    logic [DW:0]    diff;
    logic           ge;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb
    begin
        shifted = {rem_reg, q_reg[NW-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = shifted >= {1'b0, den_reg};
    end

    // Control: the step counter and the done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNW'(NW);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= cnt_reg == CNW'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Quotient bits shift in where the dividend bits leave.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            q_reg   <= {q_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule

@@ rtl/ctfc_ctrl.sv @@
module ctfc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    input  ctfc_pkg::ctfc_stat_t stat,
    output ctfc_pkg::ctfc_cmd_t  cmd
);
    localparam logic [2:0] S_ACC       = 3'd0;
    localparam logic [2:0] S_SQ        = 3'd1;
    localparam logic [2:0] S_GO        = 3'd2;
    localparam logic [2:0] S_WAIT      = 3'd3;
    localparam logic [2:0] S_SPAN      = 3'd4;
    localparam logic [2:0] S_ROOT_INIT = 3'd5;
    localparam logic [2:0] S_ROOT      = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    localparam int STEP_W = $clog2(ctfc_pkg::ROOT_STEPS);

    logic [2:0]              state_reg, state_next;
    ctfc_pkg::div_op_t       op_reg, op_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;

    // Sequencing: accumulate hits, then walk the divisions and the root once per cluster.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.div_op     = op_reg;
        in_ready       = state_reg == S_ACC;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_ACC:
            begin
                if (in_valid)
                begin
                    cmd.acc = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                cmd.qq_load = 1'b1;
                op_next     = ctfc_pkg::OP_MEAN;
                state_next  = S_GO;
            end
            S_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.div_done)
                begin
                    case (op_reg)
                        ctfc_pkg::OP_MEAN:
                        begin
                            state_next = S_SPAN;
                        end
                        ctfc_pkg::OP_RECIP:
                        begin
                            op_next    = ctfc_pkg::OP_XDIV;
                            state_next = S_GO;
                        end
                        ctfc_pkg::OP_XDIV:
                        begin
                            state_next = S_ROOT_INIT;
                        end
                        ctfc_pkg::OP_SPAN_PEAK:
                        begin
                            op_next    = ctfc_pkg::OP_SPAN_MEAN;
                            state_next = S_GO;
                        end
                        ctfc_pkg::OP_SPAN_MEAN:
                        begin
                            op_next    = ctfc_pkg::OP_PEAK_MEAN;
                            state_next = S_GO;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SPAN:
            begin
                cmd.span_load = 1'b1;
                op_next       = ctfc_pkg::OP_RECIP;
                state_next    = S_GO;
            end
            S_ROOT_INIT:
            begin
                cmd.root_init = 1'b1;
                step_next     = '0;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(ctfc_pkg::ROOT_STEPS - 1))
                begin
                    op_next    = ctfc_pkg::OP_SPAN_PEAK;
                    state_next = S_GO;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            op_reg        <= ctfc_pkg::OP_MEAN;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

@@ rtl/ctfc_dp.sv @@
module ctfc_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ctfc_pkg::ctfc_cmd_t                   cmd,
    output ctfc_pkg::ctfc_stat_t                  stat,
    input  logic                                  cfg_wr_en,
    input  logic [ctfc_pkg::DC_W-1:0]             cfg_wr_data,
    input  logic signed [ctfc_pkg::TIME_W-1:0]    hit_time,
    input  logic signed [ctfc_pkg::CHARGE_W-1:0]  hit_charge,
    input  logic                                  hit_selected,
    output logic signed [ctfc_pkg::TIME_W-1:0]    mean_time,
    output logic signed [ctfc_pkg::QSUM_W-1:0]    total_charge,
    output logic [ctfc_pkg::BAL_W-1:0]            charge_spread,
    output logic [ctfc_pkg::TIME_W-1:0]           time_span,
    output logic [ctfc_pkg::TIME_W-1:0]           span_about_mean,
    output logic [ctfc_pkg::TIME_W-1:0]           span_about_peak,
    output logic [ctfc_pkg::RATIO_W-1:0]          ratio_span_peak,
    output logic [ctfc_pkg::RATIO_W-1:0]          ratio_span_mean,
    output logic [ctfc_pkg::RATIO_W-1:0]          ratio_peak_mean,
    output logic [ctfc_pkg::TOTAL_W-1:0]          hit_total,
    output logic [ctfc_pkg::STATUS_W-1:0]         status
);
    localparam int TW     = ctfc_pkg::TIME_W;
    localparam int CW     = ctfc_pkg::CHARGE_W;
    localparam int RW     = ctfc_pkg::RATIO_W;
    localparam int NW     = ctfc_pkg::DIV_NUM_W;
    localparam int DW     = ctfc_pkg::DIV_DEN_W;
    localparam int XW     = ctfc_pkg::ROOT_W;
    localparam int LOG_H  = $clog2(ctfc_pkg::MAX_HITS);
    localparam int CNT_W  = $clog2(ctfc_pkg::MAX_HITS + 1);
    localparam int TACC_W = TW + LOG_H + 1;
    localparam int SSUM_W = CW + LOG_H;
    localparam int RCP_W  = 33;
    localparam int FRAC   = 32;
    localparam int RFRAC  = 16;

    // Cluster state.
    logic [ctfc_pkg::DC_W-1:0]     dc_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic signed [TACC_W-1:0]      tacc_reg;
    logic [ctfc_pkg::QSUM_W-1:0]   qacc_reg;
    logic signed [SSUM_W-1:0]      ssum_reg;
    logic [DW-1:0]                 sqsum_reg;
    logic signed [TW-1:0]          early_reg;
    logic signed [TW-1:0]          late_reg;
    logic signed [CW-1:0]          pkq_reg;
    logic signed [TW-1:0]          pkt_reg;

    // Finishing results.
    logic [DW-1:0]                 qq_reg;
    logic signed [TW-1:0]          mean_reg;
    logic [TW-1:0]                 span_reg;
    logic [TW-1:0]                 smean_reg;
    logic [TW-1:0]                 speak_reg;
    logic [RCP_W-1:0]              recip_reg;
    logic [NW-1:0]                 xq_reg;
    logic [RW-1:0]                 r0_reg, r1_reg, r2_reg;
    logic [XW-1:0]                 rx_reg, rr_reg, rbit_reg;
    ctfc_pkg::div_op_t             op_reg;

    // Output register.
    logic signed [TW-1:0]          mean_o_reg;
    logic [ctfc_pkg::QSUM_W-1:0]   qsum_o_reg;
    logic [ctfc_pkg::BAL_W-1:0]    bal_o_reg;
    logic [TW-1:0]                 span_o_reg, smean_o_reg, speak_o_reg;
    logic [RW-1:0]                 rsp_o_reg, rsm_o_reg, rpm_o_reg;
    logic [ctfc_pkg::TOTAL_W-1:0]  total_o_reg;
    logic [ctfc_pkg::STATUS_W-1:0] status_o_reg;

    logic                          first_hit, room;
    logic signed [2*CW-1:0]        sq;
    logic [SSUM_W-1:0]             smag;
    logic [TACC_W-1:0]             tmag;
    logic [2*SSUM_W-1:0]           prod;
    logic [NW-1:0]                 div_num, quot;
    logic [DW-1:0]                 div_den;
    logic                          div_done;
    logic [TW-1:0]                 qmean;
    logic [TW:0]                   d_span, d_me, d_lm, d_pe, d_lp;
    logic [XW-1:0]                 root_arg, root_sum;
    logic [RW-1:0]                 q_sat;
    logic                          dc_zero, qq_zero, x_big, x_low, zspk, zsm;
    logic [ctfc_pkg::BAL_W-1:0]    bal;

    // Magnitudes, square and per-hit terms.
    always_comb
    begin
        first_hit = cnt_reg == '0;
        room      = cnt_reg != CNT_W'(ctfc_pkg::MAX_HITS);
        sq        = hit_charge * hit_charge;
        smag      = ssum_reg[SSUM_W-1] ? SSUM_W'(-ssum_reg) : SSUM_W'(ssum_reg);
        tmag      = tacc_reg[TACC_W-1] ? TACC_W'(-tacc_reg) : TACC_W'(tacc_reg);
        prod      = smag * smag;
        qmean     = quot[TW-1:0];
        q_sat     = (|quot[NW-1:RW]) ? '1 : quot[RW-1:0];
    end

    // Operand selection for the shared divider.
    always_comb
    begin
        case (cmd.div_op)
            ctfc_pkg::OP_MEAN:
            begin
                div_num = NW'(tmag);
                div_den = DW'(cnt_reg);
            end
            ctfc_pkg::OP_RECIP:
            begin
                div_num = NW'(1) << FRAC;
                div_den = DW'(dc_reg);
            end
            ctfc_pkg::OP_XDIV:
            begin
                div_num = {sqsum_reg, {FRAC{1'b0}}};
                div_den = qq_reg;
            end
            ctfc_pkg::OP_SPAN_PEAK:
            begin
                div_num = NW'({span_reg, {RFRAC{1'b0}}});
                div_den = DW'(speak_reg);
            end
            ctfc_pkg::OP_SPAN_MEAN:
            begin
                div_num = NW'({span_reg, {RFRAC{1'b0}}});
                div_den = DW'(smean_reg);
            end
            ctfc_pkg::OP_PEAK_MEAN:
            begin
                div_num = NW'({speak_reg, {RFRAC{1'b0}}});
                div_den = DW'(smean_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    ctfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .done  (div_done)
    );

    assign stat.div_done = div_done;

    // Distances between the mean, the peak and the time extremes.
    always_comb
    begin
        d_span   = {late_reg[TW-1], late_reg} - {early_reg[TW-1], early_reg};
        d_me     = {mean_reg[TW-1], mean_reg} - {early_reg[TW-1], early_reg};
        d_lm     = {late_reg[TW-1], late_reg} - {mean_reg[TW-1], mean_reg};
        d_pe     = {pkt_reg[TW-1], pkt_reg} - {early_reg[TW-1], early_reg};
        d_lp     = {late_reg[TW-1], late_reg} - {pkt_reg[TW-1], pkt_reg};
        root_arg = xq_reg[XW-1:0] - XW'(recip_reg);
        root_sum = rr_reg + rbit_reg;
    end

    // Charge balance and status selection for the finished cluster.
    always_comb
    begin
        dc_zero = dc_reg == '0;
        qq_zero = qq_reg == '0;
        x_big   = |xq_reg[NW-1:XW];
        x_low   = xq_reg[XW-1:0] < XW'(recip_reg);
        zspk    = speak_reg == '0;
        zsm     = smean_reg == '0;
        if (dc_zero || (!qq_zero && !x_big && x_low))
        begin
            bal = '0;
        end
        else if (qq_zero || x_big)
        begin
            bal = '1;
        end
        else
        begin
            bal = rr_reg[ctfc_pkg::BAL_W-1:0];
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg <= ctfc_pkg::DC_RESET;
        end
        else if (cfg_wr_en)
        begin
            dc_reg <= cfg_wr_data;
        end
    end

    // Running sums and extremes; loading the result register clears them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            tacc_reg  <= '0;
            qacc_reg  <= '0;
            ssum_reg  <= '0;
            sqsum_reg <= '0;
            early_reg <= '0;
            late_reg  <= '0;
            pkq_reg   <= '0;
            pkt_reg   <= '0;
        end
        else if (cmd.out_load)
        begin
            cnt_reg   <= '0;
            tacc_reg  <= '0;
            qacc_reg  <= '0;
            ssum_reg  <= '0;
            sqsum_reg <= '0;
            early_reg <= '0;
            late_reg  <= '0;
            pkq_reg   <= '0;
            pkt_reg   <= '0;
        end
        else if (cmd.acc && room)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            tacc_reg <= tacc_reg + TACC_W'(hit_time);
            qacc_reg <= qacc_reg + ctfc_pkg::QSUM_W'(hit_charge);
            if (hit_selected)
            begin
                ssum_reg  <= ssum_reg + SSUM_W'(hit_charge);
                sqsum_reg <= sqsum_reg + DW'(unsigned'(sq));
            end
            if (first_hit || hit_time < early_reg)
            begin
                early_reg <= hit_time;
            end
            if (first_hit || hit_time > late_reg)
            begin
                late_reg <= hit_time;
            end
            if (first_hit || hit_charge > pkq_reg)
            begin
                pkq_reg <= hit_charge;
                pkt_reg <= hit_time;
            end
        end
    end

    // Finishing steps: divider results, spans and the digit-by-digit root.
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            op_reg <= cmd.div_op;
        end
        if (cmd.qq_load)
        begin
            qq_reg <= DW'(prod);
        end
        if (cmd.span_load)
        begin
            span_reg  <= d_span[TW-1:0];
            smean_reg <= (d_me > d_lm) ? d_me[TW-1:0] : d_lm[TW-1:0];
            speak_reg <= (d_pe > d_lp) ? d_pe[TW-1:0] : d_lp[TW-1:0];
        end
        if (div_done)
        begin
            case (op_reg)
                ctfc_pkg::OP_MEAN:
                begin
                    mean_reg <= tacc_reg[TACC_W-1] ? TW'(-qmean) : qmean;
                end
                ctfc_pkg::OP_RECIP:
                begin
                    recip_reg <= quot[RCP_W-1:0];
                end
                ctfc_pkg::OP_XDIV:
                begin
                    xq_reg <= quot;
                end
                ctfc_pkg::OP_SPAN_PEAK:
                begin
                    r0_reg <= q_sat;
                end
                ctfc_pkg::OP_SPAN_MEAN:
                begin
                    r1_reg <= q_sat;
                end
                ctfc_pkg::OP_PEAK_MEAN:
                begin
                    r2_reg <= q_sat;
                end
                default:
                begin
                    r2_reg <= r2_reg;
                end
            endcase
        end
        if (cmd.root_init)
        begin
            rx_reg   <= root_arg;
            rr_reg   <= '0;
            rbit_reg <= XW'(1) << (XW - 2);
        end
        else if (cmd.root_step)
        begin
            if (rx_reg >= root_sum)
            begin
                rx_reg <= rx_reg - root_sum;
                rr_reg <= (rr_reg >> 1) + rbit_reg;
            end
            else
            begin
                rr_reg <= rr_reg >> 1;
            end
            rbit_reg <= rbit_reg >> 2;
        end
    end

    // Output register, loaded when the previous result has been taken.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mean_o_reg   <= mean_reg;
            qsum_o_reg   <= qacc_reg;
            bal_o_reg    <= bal;
            span_o_reg   <= span_reg;
            smean_o_reg  <= smean_reg;
            speak_o_reg  <= speak_reg;
            rsp_o_reg    <= zspk ? '1 : r0_reg;
            rsm_o_reg    <= zsm ? '1 : r1_reg;
            rpm_o_reg    <= zsm ? '1 : r2_reg;
            total_o_reg  <= ctfc_pkg::TOTAL_W'(cnt_reg);
            status_o_reg <= {dc_zero || (!qq_zero && !x_big && x_low),
                             dc_zero || qq_zero || zspk || zsm};
        end
    end

    assign mean_time       = mean_o_reg;
    assign total_charge    = qsum_o_reg;
    assign charge_spread   = bal_o_reg;
    assign time_span       = span_o_reg;
    assign span_about_mean = smean_o_reg;
    assign span_about_peak = speak_o_reg;
    assign ratio_span_peak = rsp_o_reg;
    assign ratio_span_mean = rsm_o_reg;
    assign ratio_peak_mean = rpm_o_reg;
    assign hit_total       = total_o_reg;
    assign status          = status_o_reg;
endmodule

@@ bench/tb_cluster_time_charge_features_core.sv @@
`timescale 1ns / 100ps

module tb_cluster_time_charge_features_core;

    localparam int TIME_W   = ctfc_pkg::TIME_W;
    localparam int CHARGE_W = ctfc_pkg::CHARGE_W;
    localparam int QSUM_W   = ctfc_pkg::QSUM_W;
    localparam int BAL_W    = ctfc_pkg::BAL_W;
    localparam int RATIO_W  = ctfc_pkg::RATIO_W;
    localparam int TOTAL_W  = ctfc_pkg::TOTAL_W;
    localparam int STATUS_W = ctfc_pkg::STATUS_W;
    localparam int DC_W     = ctfc_pkg::DC_W;

    // One hit as the driver presents it.
    typedef struct {
        logic signed [TIME_W-1:0]   hit_time;
        logic signed [CHARGE_W-1:0] hit_charge;
        logic                       hit_selected;
        logic                       last_hit;
    } hit_t;

    // One feature set as the block reports it.
    typedef struct {
        logic signed [TIME_W-1:0] mean_time;
        logic signed [QSUM_W-1:0] total_charge;
        logic [BAL_W-1:0]         charge_spread;
        logic [TIME_W-1:0]        time_span;
        logic [TIME_W-1:0]        span_about_mean;
        logic [TIME_W-1:0]        span_about_peak;
        logic [RATIO_W-1:0]       ratio_span_peak;
        logic [RATIO_W-1:0]       ratio_span_mean;
        logic [RATIO_W-1:0]       ratio_peak_mean;
        logic [TOTAL_W-1:0]       hit_total;
        logic [STATUS_W-1:0]      status;
    } feat_t;

    localparam int HIT_LIMIT = ctfc_pkg::MAX_HITS;
    localparam int DRAIN_CYCLES = 800;
    localparam int HOLD_CYCLES = 4000;

    // Idle modes of the two sides.
    typedef enum int { MODE_SRC_IDLE, MODE_SNK_IDLE, MODE_NO_IDLE } idle_mode_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [DC_W-1:0] cfg_wr_data;

    ctfc_hit_if  hit_ch ();
    ctfc_feat_if feat_ch ();

    cluster_time_charge_features_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .hit_in     (hit_ch.sink),
        .feat_out   (feat_ch.source),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    hit_t  pending_hits[$];
    feat_t expected_features[$];
    int error_count = 0;
    idle_mode_t idle_mode = MODE_SRC_IDLE;
    bit hold_start = 1'b0;
    bit hold_off = 1'b0;

    // Predictor copy of the cluster state.
    logic [DC_W-1:0] det_count;
    int unsigned     n_hits;
    longint          time_sum;
    longint          charge_sum;
    longint          sel_sum;
    longint unsigned sel_sq_sum;
    longint          t_first;
    longint          t_last;
    longint          q_peak;
    longint          t_peak;

    always #1 clk = ~clk;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned ratio16(input longint unsigned num,
                                                input longint unsigned den,
                                                inout logic [1:0] st);
        longint unsigned q;
        if (den == 0)
        begin
            st[0] = 1'b1;
            return 64'hFFFFFF;
        end
        q = (num << 16) / den;
        return (q > 64'hFFFFFF) ? 64'hFFFFFF : q;
    endfunction

    function automatic longint unsigned spread_of(inout logic [1:0] st);
        longint unsigned mag, qq, ip, rem, frac, x, recip, root;
        mag = (sel_sum < 0) ? longint'(-sel_sum) : sel_sum;
        qq = mag * mag;
        frac = 0;
        if (det_count == 0)
        begin
            st = 2'b11;
            return 0;
        end
        if (qq == 0)
        begin
            st[0] = 1'b1;
            return 64'hFFFFF;
        end
        ip = sel_sq_sum / qq;
        if (ip >= 256) return 64'hFFFFF;
        rem = sel_sq_sum % qq;
        // Long division for 32 fraction bits; rem < qq <= 2^62 so no overflow.
        for (int i = 0; i < 32; i++)
        begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= qq)
            begin
                rem = rem - qq;
                frac = frac | 1;
            end
        end
        x = (ip << 32) | frac;
        recip = (64'd1 << 32) / det_count;
        if (x < recip)
        begin
            st[1] = 1'b1;
            return 0;
        end
        root = int_sqrt(x - recip);
        return (root > 64'hFFFFF) ? 64'hFFFFF : root;
    endfunction

    task automatic clear_cluster();
        n_hits = 0; time_sum = 0; charge_sum = 0; sel_sum = 0; sel_sq_sum = 0;
        t_first = 0; t_last = 0; q_peak = 0; t_peak = 0;
    endtask

    task automatic queue_hit(input hit_t h);
        pending_hits.insert(pending_hits.size(), h);
    endtask

    // Fold one accepted hit into the cluster and queue the features on a last hit.
    task automatic accumulate_hit(input hit_t h);
        longint t, q, mean;
        longint unsigned span, smean, speak, a, b;
        logic [1:0] st;
        feat_t f;
        t = h.hit_time;
        q = h.hit_charge;
        st = 2'b00;
        if (n_hits < HIT_LIMIT)
        begin
            if (n_hits == 0)
            begin
                t_first = t; t_last = t; q_peak = q; t_peak = t;
            end
            else
            begin
                if (t < t_first) t_first = t;
                if (t > t_last) t_last = t;
                if (q > q_peak)
                begin
                    q_peak = q;
                    t_peak = t;
                end
            end
            n_hits++;
            time_sum += t;
            charge_sum += q;
            if (h.hit_selected)
            begin
                sel_sum += q;
                sel_sq_sum += longint'(q * q);
            end
        end
        if (!h.last_hit) return;
        mean = time_sum / longint'(n_hits);
        span = t_last - t_first;
        a = mean - t_first;
        b = t_last - mean;
        smean = (a > b) ? a : b;
        a = t_peak - t_first;
        b = t_last - t_peak;
        speak = (a > b) ? a : b;
        f.mean_time       = mean[TIME_W-1:0];
        f.total_charge    = charge_sum[QSUM_W-1:0];
        f.charge_spread   = BAL_W'(spread_of(st));
        f.time_span       = span[TIME_W-1:0];
        f.span_about_mean = smean[TIME_W-1:0];
        f.span_about_peak = speak[TIME_W-1:0];
        f.ratio_span_peak = RATIO_W'(ratio16(span, speak, st));
        f.ratio_span_mean = RATIO_W'(ratio16(span, smean, st));
        f.ratio_peak_mean = RATIO_W'(ratio16(speak, smean, st));
        f.hit_total       = n_hits[TOTAL_W-1:0];
        f.status          = st;
        expected_features.insert(expected_features.size(), f);
        clear_cluster();
    endtask

    // Driver: offers pending hits, predicts each transfer, holds an offered hit until taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hit_ch.valid && hit_ch.ready)
            begin
                accumulate_hit('{hit_ch.hit_time, hit_ch.hit_charge,
                                 hit_ch.hit_selected, hit_ch.last_hit});
                void'(pending_hits.pop_front());
            end
            if (!(hit_ch.valid && !hit_ch.ready))
            begin
                if (pending_hits.size() != 0 &&
                    !(idle_mode == MODE_SRC_IDLE && $urandom_range(99) < 38) &&
                    !(idle_mode == MODE_SNK_IDLE && $urandom_range(99) < 57))
                begin
                    hit_ch.valid        <= 1'b1;
                    hit_ch.hit_time     <= pending_hits[0].hit_time;
                    hit_ch.hit_charge   <= pending_hits[0].hit_charge;
                    hit_ch.hit_selected <= pending_hits[0].hit_selected;
                    hit_ch.last_hit     <= pending_hits[0].last_hit;
                end
                else
                    hit_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted in cycles on its own.
    initial
    begin
        wait (hold_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Monitor and receiver: checks each feature transfer, drives ready.
    always @(posedge clk)
    begin
        feat_t e;
        if (rst_n)
        begin
            if (feat_ch.valid && feat_ch.ready)
            begin
                if (expected_features.size() == 0)
                    report("unexpected result", 0, 0);
                else
                begin
                    e = expected_features.pop_front();
                    if (feat_ch.mean_time !== e.mean_time)
                        report("mean_time", feat_ch.mean_time, e.mean_time);
                    if (feat_ch.total_charge !== e.total_charge)
                        report("total_charge", feat_ch.total_charge, e.total_charge);
                    if (feat_ch.charge_spread !== e.charge_spread)
                        report("charge_spread", feat_ch.charge_spread, e.charge_spread);
                    if (feat_ch.time_span !== e.time_span)
                        report("time_span", feat_ch.time_span, e.time_span);
                    if (feat_ch.span_about_mean !== e.span_about_mean)
                        report("span_about_mean", feat_ch.span_about_mean,
                               e.span_about_mean);
                    if (feat_ch.span_about_peak !== e.span_about_peak)
                        report("span_about_peak", feat_ch.span_about_peak,
                               e.span_about_peak);
                    if (feat_ch.ratio_span_peak !== e.ratio_span_peak)
                        report("ratio_span_peak", feat_ch.ratio_span_peak,
                               e.ratio_span_peak);
                    if (feat_ch.ratio_span_mean !== e.ratio_span_mean)
                        report("ratio_span_mean", feat_ch.ratio_span_mean,
                               e.ratio_span_mean);
                    if (feat_ch.ratio_peak_mean !== e.ratio_peak_mean)
                        report("ratio_peak_mean", feat_ch.ratio_peak_mean,
                               e.ratio_peak_mean);
                    if (feat_ch.hit_total !== e.hit_total)
                        report("hit_total", feat_ch.hit_total, e.hit_total);
                    if (feat_ch.status !== e.status)
                        report("status", feat_ch.status, e.status);
                end
            end
            if (hold_off)
                feat_ch.ready <= 1'b0;
            else if (idle_mode == MODE_SRC_IDLE)
                feat_ch.ready <= ($urandom_range(99) >= 57);
            else if (idle_mode == MODE_SNK_IDLE)
                feat_ch.ready <= ($urandom_range(99) >= 38);
            else
                feat_ch.ready <= 1'b1;
        end
    end

    function automatic hit_t rand_hit(input bit last);
        hit_t h;
        h.hit_time     = TIME_W'($urandom);
        h.hit_charge   = CHARGE_W'($urandom);
        h.hit_selected = 1'($urandom_range(1));
        h.last_hit     = last;
        // Mostly narrow values so sums stay meaningful, sometimes full range.
        if ($urandom_range(3) != 0)
        begin
            h.hit_time   = TIME_W'($signed($urandom_range(4000)) - 2000);
            h.hit_charge = CHARGE_W'($signed($urandom_range(20000)) - 5000);
        end
        return h;
    endfunction

    task automatic add_cluster(input int len);
        for (int i = 0; i < len; i++)
            queue_hit(rand_hit(i == len - 1));
    endtask

    task automatic wait_idle();
        while (pending_hits.size() != 0 || hit_ch.valid || expected_features.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [DC_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        det_count   = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_clusters(input int hits);
        int n;
        int len;
        n = 0;
        while (n < hits)
        begin
            case ($urandom_range(9))
                0: len = 1;
                1: len = $urandom_range(250, 262);
                default: len = $urandom_range(2, 12);
            endcase
            add_cluster(len);
            n += len;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        hit_ch.valid = 1'b0;
        hit_ch.hit_time = '0;
        hit_ch.hit_charge = '0;
        hit_ch.hit_selected = 1'b0;
        hit_ch.last_hit = 1'b0;
        feat_ch.ready = 1'b0;
        det_count = ctfc_pkg::DC_RESET;
        clear_cluster();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single hit, extremes, no selected hits, equal peaks, balance cases.
        queue_hit('{31'sd100, 24'sd50, 1'b1, 1'b1});
        queue_hit('{31'h40000000, 24'h800000, 1'b1, 1'b0});
        queue_hit('{31'sd1073741823, 24'sd8388607, 1'b1, 1'b1});
        queue_hit('{31'sd5, 24'sd10, 1'b0, 1'b0});
        queue_hit('{31'sd9, 24'sd10, 1'b0, 1'b1});
        queue_hit('{31'sd1, 24'sd300, 1'b1, 1'b0});
        queue_hit('{31'sd2, 24'sd300, 1'b1, 1'b0});
        queue_hit('{31'sd3, 24'sd300, 1'b1, 1'b1});
        queue_hit('{31'sd0, 24'sd1000, 1'b1, 1'b0});
        queue_hit('{31'sd7, -24'sd999, 1'b1, 1'b1});
        queue_hit('{-31'sd7, 24'sd0, 1'b1, 1'b0});
        queue_hit('{-31'sd3, 24'sd0, 1'b0, 1'b1});
        queue_hit('{31'sd0, 24'sd0, 1'b0, 1'b1});
        wait_idle();

        // Hit limit: 300 hits in one cluster.
        idle_mode = MODE_SNK_IDLE;
        add_cluster(300);
        random_clusters(300);
        wait_idle();

        // Pressure: receiver holds off while clusters keep arriving.
        idle_mode = MODE_NO_IDLE;
        write_count(10'd1023);
        hold_start = 1'b1;
        for (int i = 0; i < 8; i++) add_cluster(3);
        random_clusters(200);
        wait_idle();

        write_count(10'd0);
        random_clusters(150);
        wait_idle();
        write_count(10'd1);
        random_clusters(150);
        wait_idle();
        idle_mode = MODE_SRC_IDLE;
        write_count(DC_W'($urandom_range(1, 1023)));
        random_clusters(200);
        wait_idle();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
